// ===== design/dqp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types and constants for the DNS query question parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

  localparam int MAX_QUESTIONS  = 32;
  localparam int MAX_NAME_CHARS = 253;

  // Result queue depth; two slots must be free to take a byte.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Result kinds
  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_QUESTION = 2'd1;
  localparam logic [1:0] KIND_MESSAGE  = 2'd2;

  // Status codes (also the stored error codes)
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR = 3'd1;
  localparam logic [2:0] ST_RESPONSE  = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_BAD_NAME  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_LEN    = 6'b000010,
    PH_CHARS  = 6'b000100,
    PH_TC     = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_ERR    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [15:0] section_end;
    logic [5:0]  question_total;
    logic [15:0] reply_flags;
    logic [2:0]  status;
    logic        is_a_in;
    logic [7:0]  name_length;
    logic [13:0] name_pos;
    logic [7:0]  name_char;
    logic [1:0]  result_kind;
  } result_t;

  // Up to two result words produced by one accepted byte, packed to the front.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== design/dqp_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_parse
// Header check, question walk; one byte per cycle on accept, up to two words.
// ----------------------------------------------------------------------------
module dqp_parse
  import dqp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output push_t      push
);

  logic [15:0] byte_position, byte_position_next;
  phase_t      parse_phase, parse_phase_next;
  logic [15:0] header_flags, header_flags_next;
  logic [15:0] declared_questions, declared_questions_next;
  logic [5:0]  questions_done, questions_done_next;
  logic [5:0]  label_left, label_left_next;
  logic [7:0]  name_count, name_count_next;
  logic [15:0] name_start, name_start_next;
  logic [31:0] type_class_shift, type_class_shift_next;
  logic [2:0]  error_code, error_code_next;
  logic [15:0] section_end_mark, section_end_mark_next;

  logic [15:0] pos_inc;
  logic [8:0]  need;
  logic        main_valid;
  result_t     main_res;
  result_t     final_res;
  logic [2:0]  final_status;

  always_comb begin
    pos_inc = (byte_position == 16'hFFFF) ? byte_position : byte_position + 16'd1;
  end

  always_comb begin
    byte_position_next      = pos_inc;
    parse_phase_next        = parse_phase;
    header_flags_next       = header_flags;
    declared_questions_next = declared_questions;
    questions_done_next     = questions_done;
    label_left_next         = label_left;
    name_count_next         = name_count;
    name_start_next         = name_start;
    type_class_shift_next   = type_class_shift;
    error_code_next         = error_code;
    section_end_mark_next   = section_end_mark;
    need         = ((name_count != 8'd0) ? {1'b0, name_count} + 9'd1 : 9'd0)
                   + {1'b0, data_byte};
    main_valid   = 1'b0;
    main_res     = '0;
    final_res    = '0;
    final_status = ST_OK;

    unique case (parse_phase)
      PH_HEADER: begin
        if (byte_position == 16'd2) header_flags_next[15:8] = data_byte;
        else if (byte_position == 16'd3) header_flags_next[7:0] = data_byte;
        else if (byte_position == 16'd4) declared_questions_next[15:8] = data_byte;
        else if (byte_position == 16'd5) declared_questions_next[7:0] = data_byte;
        if (byte_position >= 16'd11) begin
          if (header_flags[15]) begin
            error_code_next  = ST_RESPONSE;
            parse_phase_next = PH_ERR;
          end else if (declared_questions == 16'd0 ||
                       declared_questions > 16'(MAX_QUESTIONS)) begin
            error_code_next  = ST_BAD_COUNT;
            parse_phase_next = PH_ERR;
          end else begin
            name_start_next  = pos_inc;
            name_count_next  = 8'd0;
            label_left_next  = 6'd0;
            parse_phase_next = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        if (name_count == 8'd0 && name_start > 16'h3FFF) begin
          error_code_next  = ST_BAD_NAME;
          parse_phase_next = PH_ERR;
        end else if (data_byte == 8'd0) begin
          if (name_count == 8'd0) begin
            // root name
            error_code_next  = ST_BAD_NAME;
            parse_phase_next = PH_ERR;
          end else begin
            parse_phase_next      = PH_TC;
            label_left_next       = 6'd4;
            type_class_shift_next = '0;
          end
        end else if (data_byte > 8'd63) begin
          error_code_next  = ST_BAD_NAME;
          parse_phase_next = PH_ERR;
        end else if (need > 9'(MAX_NAME_CHARS)) begin
          error_code_next  = ST_BAD_NAME;
          parse_phase_next = PH_ERR;
        end else begin
          if (name_count != 8'd0) begin
            main_valid           = 1'b1;
            main_res.result_kind = KIND_CHAR;
            main_res.name_char   = 8'h2E;
            name_count_next      = name_count + 8'd1;
          end
          label_left_next  = data_byte[5:0];
          parse_phase_next = PH_CHARS;
        end
      end
      PH_CHARS: begin
        main_valid           = 1'b1;
        main_res.result_kind = KIND_CHAR;
        main_res.name_char   = (data_byte >= 8'h41 && data_byte <= 8'h5A) ?
                               data_byte + 8'h20 : data_byte;
        name_count_next      = name_count + 8'd1;
        label_left_next      = (label_left != 6'd0) ? label_left - 6'd1 : 6'd0;
        if (label_left_next == 6'd0) parse_phase_next = PH_LEN;
      end
      PH_TC: begin
        type_class_shift_next = {type_class_shift[23:0], data_byte};
        label_left_next       = (label_left != 6'd0) ? label_left - 6'd1 : 6'd0;
        if (label_left_next == 6'd0) begin
          questions_done_next  = questions_done + 6'd1;
          main_valid           = 1'b1;
          main_res.result_kind = KIND_QUESTION;
          main_res.name_pos    = name_start[13:0];
          main_res.name_length = name_count;
          main_res.is_a_in     = (type_class_shift_next == 32'h0001_0001);
          if ({10'd0, questions_done_next} >= declared_questions) begin
            parse_phase_next      = PH_DONE;
            section_end_mark_next = pos_inc;
          end else begin
            name_start_next  = pos_inc;
            name_count_next  = 8'd0;
            label_left_next  = 6'd0;
            parse_phase_next = PH_LEN;
          end
        end
      end
      PH_DONE, PH_ERR: begin
      end
      default: begin
      end
    endcase

    if (error_code_next != ST_OK) final_status = error_code_next;
    else if (parse_phase_next == PH_DONE) final_status = ST_OK;
    else if (parse_phase_next == PH_HEADER) final_status = ST_SHORT_HDR;
    else final_status = ST_TRUNCATED;

    final_res.result_kind    = KIND_MESSAGE;
    final_res.status         = final_status;
    final_res.reply_flags    = (final_status == ST_SHORT_HDR) ? 16'h0000 :
                               (16'h8080 | (header_flags_next & 16'h7900));
    final_res.question_total = questions_done_next;
    final_res.section_end    = (final_status == ST_OK) ? section_end_mark_next : 16'd0;

    // End of message: restart for the next one
    if (last_byte) begin
      byte_position_next      = '0;
      parse_phase_next        = PH_HEADER;
      header_flags_next       = '0;
      declared_questions_next = '0;
      questions_done_next     = '0;
      label_left_next         = '0;
      name_count_next         = '0;
      name_start_next         = '0;
      type_class_shift_next   = '0;
      error_code_next         = ST_OK;
      section_end_mark_next   = '0;
    end

    // Pack the words to the front
    push = '0;
    if (accept) begin
      if (main_valid) begin
        push.first  = main_res;
        push.second = final_res;
        push.count  = last_byte ? 2'd2 : 2'd1;
      end else begin
        push.first = final_res;
        push.count = last_byte ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      parse_phase        <= PH_HEADER;
      header_flags       <= '0;
      declared_questions <= '0;
      questions_done     <= '0;
      label_left         <= '0;
      name_count         <= '0;
      name_start         <= '0;
      type_class_shift   <= '0;
      error_code         <= ST_OK;
      section_end_mark   <= '0;
    end else if (accept) begin
      byte_position      <= byte_position_next;
      parse_phase        <= parse_phase_next;
      header_flags       <= header_flags_next;
      declared_questions <= declared_questions_next;
      questions_done     <= questions_done_next;
      label_left         <= label_left_next;
      name_count         <= name_count_next;
      name_start         <= name_start_next;
      type_class_shift   <= type_class_shift_next;
      error_code         <= error_code_next;
      section_end_mark   <= section_end_mark_next;
    end
  end

endmodule

// ===== design/dqp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_fifo
// Small result queue: takes up to two words a cycle, gives one on out_ready.
// ----------------------------------------------------------------------------
module dqp_fifo
  import dqp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid & out_ready;
  assign room      = (count <= FIFO_CW'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr + FIFO_AW'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (pop) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count  <= count + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end
  end

endmodule

// ===== design/dns_query_question_parser_top.sv =====
`timescale 1ns / 1ps
// Throughput: one byte per cycle while s_axis_tready is high; each byte gives
//   at most one word, except the last byte of a message, which can give two
//   (a character or question word, then the message word). A four-word result
//   queue absorbs that burst.
// Reset: rst (synchronous) returns the parser to the header phase and empties
//   the result queue.
// ----------------------------------------------------------------------------
// dns_query_question_parser_top
// Checks a DNS query header, walks its question names, and streams out the
// lowercased names, one word per question, and a final status word.
// ----------------------------------------------------------------------------
module dns_query_question_parser_top
  import dqp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] name_char, [21:8] name_pos, [29:22] name_length, [30] is_a_in,
  // [33:31] status, [49:34] reply_flags, [55:50] question_total,
  // [71:56] section_end
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // result_kind
);

  logic    accept;
  logic    room;
  push_t   push;
  result_t head;

  // Take a byte only while two queue slots are free, so a message-end burst
  // always fits even with the output stalled.
  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid & room;

  dqp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .push      (push)
  );

  dqp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (head)
  );

  // Drive the word fields lowest first, kind on the side band
  assign m_axis_tdata = {head.section_end, head.question_total, head.reply_flags,
                         head.status, head.is_a_in, head.name_length,
                         head.name_pos, head.name_char};
  assign m_axis_tuser = head.result_kind;

endmodule
